@@ src/arpc_pkg.sv @@
// shared types and constants for the arp address cache
// no dependencies; imported by every module of the block
package arpc_pkg;

    localparam int unsigned CACHE_ENTRIES_DEF = 16;
    localparam int unsigned IP_W  = 32;
    localparam int unsigned MAC_W = 48;

    typedef enum logic {
        ACT_LOOKUP = 1'b0,
        ACT_STORE  = 1'b1
    } t_action;

    typedef struct packed {
        t_action          action;
        logic [IP_W-1:0]  ip_address;
        logic [MAC_W-1:0] mac_address;
    } t_in_word;

    typedef struct packed {
        logic             hit;
        logic [MAC_W-1:0] mac_found;
        logic             stored;
    } t_out_word;

    // write request into the entry table
    typedef struct packed {
        logic             en;
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
    } t_tbl_wr;

endpackage

@@ src/arpc_pick.sv @@
// lowest-index pick: turns a request vector into a one-hot select
// depends on arpc_pkg only through the default entry count
module arpc_pick #(
    parameter int unsigned CACHE_ENTRIES = arpc_pkg::CACHE_ENTRIES_DEF
) (
    input  logic [CACHE_ENTRIES-1:0] i_req,
    output logic [CACHE_ENTRIES-1:0] o_sel,
    output logic                     o_found
);
    import arpc_pkg::*;

    // isolate lowest set bit: x & -x
    assign o_sel   = i_req & (~i_req + {{(CACHE_ENTRIES-1){1'b0}}, 1'b1});
    assign o_found = |i_req;

endmodule

@@ src/arpc_table.sv @@
// entry table: valid bits, addresses and macs with a parallel address compare
// uses arpc_pkg for the field widths and the write request struct
module arpc_table #(
    parameter int unsigned CACHE_ENTRIES = arpc_pkg::CACHE_ENTRIES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [arpc_pkg::IP_W-1:0]    i_query_ip,
    output logic [CACHE_ENTRIES-1:0]     o_match,
    output logic [CACHE_ENTRIES-1:0]     o_free,
    input  logic [CACHE_ENTRIES-1:0]     i_sel,
    output logic [arpc_pkg::MAC_W-1:0]   o_rd_mac,
    input  arpc_pkg::t_tbl_wr            i_wr
);
    import arpc_pkg::*;

    logic [CACHE_ENTRIES-1:0] r_valid;
    logic [IP_W-1:0]          r_ip  [CACHE_ENTRIES];
    logic [MAC_W-1:0]         r_mac [CACHE_ENTRIES];

    // address and mac only looked at behind the valid bit
    always_comb begin
        for (int k = 0; k < CACHE_ENTRIES; k++) begin
            o_match[k] = r_valid[k] && (r_ip[k] == i_query_ip);
            o_free[k]  = !r_valid[k];
        end
    end

    always_comb begin
        o_rd_mac = '0;
        for (int k = 0; k < CACHE_ENTRIES; k++) begin
            o_rd_mac = o_rd_mac | (r_mac[k] & {MAC_W{i_sel[k]}});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid <= r_valid | i_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < CACHE_ENTRIES; k++) begin
            if (i_wr.en && i_sel[k]) begin
                r_ip[k]  <= i_wr.ip;
                r_mac[k] <= i_wr.mac;
            end
        end
    end

    a_wr_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr.en |-> $onehot(i_sel))
        else $error("table write without a single selected entry");

    a_written_not_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr.en |=> ((o_free & $past(i_sel)) == '0))
        else $error("written entry still reads as free");

    a_free_never_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> ($countones(o_free) <= $past($countones(o_free))))
        else $error("free entry count increased without reset");

endmodule

@@ src/arp_address_cache_core.sv @@
// top level of the arp address cache: input register, table, pick, result register
// uses arpc_pkg, arpc_table and arpc_pick
//
// Fully associative ipv4-to-mac cache of CACHE_ENTRIES entries. Each word is a
// lookup or a store and gives exactly one result word. The block takes one word
// per clock unless the result register is held by an output stall: the word is
// registered, then compared against all entries at once, the lowest matching
// (lookup) or lowest free-or-matching (store) entry is picked, and the result
// is registered. That one compare-and-pick stage sets the cycle. A store updates
// the table as its result is registered, so the next word already sees it. A
// lookup miss returns zero mac; a store into a full table with the address
// absent is dropped and reported with stored low. Valid bits clear on reset.
module arp_address_cache_core #(
    parameter int unsigned CACHE_ENTRIES = arpc_pkg::CACHE_ENTRIES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  arpc_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output arpc_pkg::t_out_word o_out_word
);
    import arpc_pkg::*;

    logic      r_in_valid;
    t_in_word  r_in;
    logic      r_out_valid;
    t_out_word r_out;
    t_out_word n_out;

    logic                     adv;
    logic                     is_store;
    logic [CACHE_ENTRIES-1:0] match;
    logic [CACHE_ENTRIES-1:0] free;
    logic [CACHE_ENTRIES-1:0] req;
    logic [CACHE_ENTRIES-1:0] sel;
    logic                     found;
    logic [MAC_W-1:0]         rd_mac;
    t_tbl_wr                  wr;

    // stage moves when the result register is empty or being taken
    assign adv        = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !adv;
    assign is_store   = (r_in.action == ACT_STORE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_word;
        end
    end

    arpc_table #(
        .CACHE_ENTRIES(CACHE_ENTRIES)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_query_ip(r_in.ip_address),
        .o_match   (match),
        .o_free    (free),
        .i_sel     (sel),
        .o_rd_mac  (rd_mac),
        .i_wr      (wr)
    );

    // store may take a free entry or overwrite its own address
    assign req = is_store ? (free | match) : match;

    arpc_pick #(
        .CACHE_ENTRIES(CACHE_ENTRIES)
    ) u_pick (
        .i_req  (req),
        .o_sel  (sel),
        .o_found(found)
    );

    always_comb begin
        wr.en  = adv && is_store && found;
        wr.ip  = r_in.ip_address;
        wr.mac = r_in.mac_address;

        n_out.hit       = !is_store && found;
        n_out.mac_found = (!is_store && found) ? rd_mac : '0;
        n_out.stored    = is_store && found;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    a_hit_xor_stored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.hit && r_out.stored))
        else $error("result word reports both hit and stored");

    a_miss_zero_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.hit) |-> (r_out.mac_found == '0))
        else $error("non-hit result carries a mac");

    a_write_only_on_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr.en |-> (adv && is_store && $onehot(sel)))
        else $error("table written outside an advancing store");

endmodule
